/* rtl/wbs_pkg.sv */
// Package for the weighted 3x3 blur stream: pixel, command and result types,
// frame limits, filter constants and configuration register indexes.
// No dependencies; every other file of the block but wbs_ram imports it.
package wbs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	localparam int COL_W    = 10;
	localparam int ROW_W    = 12;
	localparam int FWIDTH_W = 11;
	localparam int FHEIGHT_W = 13;
	localparam int PEND_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int ADDR_W = $clog2(MAX_WIDTH);

	// Weighted sum per channel is at most 18 * 255, which fits in 13 bits.
	localparam int SUM_W = 13;
	// Division by 18: multiply by ceil(2^16 / 18) and shift right by 16.
	// Exact for every sum below 32768.
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_18 = RECIP_W'(3641);
	localparam logic [7:0] OPAQUE = 8'hFF;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd2;

	// Channel 0 is red, 1 green, 2 blue, 3 alpha.
	typedef logic [3:0][7:0] pixel_t;

	typedef struct packed {
		logic [FWIDTH_W-1:0]  frame_width;
		logic [FHEIGHT_W-1:0] frame_height;
		logic                 filter_enable;
	} cfg_t;

	// One unit of work for the back part.
	// Pixel: col is the write/read address, edge_addr the last column,
	//   use_edge selects the last-column pixel of the row two above as output.
	// Drain: use_edge selects the upper store at edge_addr, else the middle
	//   store at col.
	typedef struct packed {
		logic              is_drain;
		logic              emit;
		logic              blur;
		logic              use_edge;
		logic [ADDR_W-1:0] col;
		logic [ADDR_W-1:0] edge_addr;
		pixel_t            px;
		logic [COL_W-1:0]  ocol;
		logic [ROW_W-1:0]  orow;
		logic              last;
	} cmd_t;

	typedef struct packed {
		pixel_t           px;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} res_t;

endpackage

/* rtl/weighted_3x3_blur_stream.sv */
// Top level of the weighted 3x3 blur stream: configuration registers and the
// front part, command queue and back part wired together.
// Depends on wbs_pkg, wbs_front, wbs_cmd_queue and wbs_back.
//
//   Channel  | Handshake             | Transaction carries
//   ---------+-----------------------+---------------------------------------------
//   input    | push / full           | kind, in_red, in_green, in_blue, in_alpha
//   result   | empty / pop           | out_red..out_alpha, out_col, out_row, frame_last
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The block takes one input transaction per clock while full is low and sustains
// one result per clock while pop keeps up; the rate is set by the combinational
// front classifier and the one command the back part issues per cycle to its row stores.
// A result is registered in the command queue, the store read, the weighted sum
// and the result queue, in that order, after the pixel transaction that releases it.
// Reset is asynchronous and active low; it clears the counters, the queues and
// the window. The row stores are not cleared and need no clearing pass.
// When the result queue has no slot left for the results in flight, the back part
// stops taking commands, the command queue fills and full rises; the two parts otherwise stall on their own.
module weighted_3x3_blur_stream import wbs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  kind,
	input  logic [7:0]            in_red,
	input  logic [7:0]            in_green,
	input  logic [7:0]            in_blue,
	input  logic [7:0]            in_alpha,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_alpha,
	output logic [COL_W-1:0]      out_col,
	output logic [ROW_W-1:0]      out_row,
	output logic                  frame_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	logic   accept;
	pixel_t in_px;
	logic   cmd_push;
	cmd_t   cmd_front;
	logic   cmd_valid;
	logic   cmd_pop;
	cmd_t   cmd_back;
	res_t   res;

	// Configuration writes are always taken. Writes to the unused index are
	// accepted and have no effect.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= FWIDTH_W'(320);
			cfg_q.frame_height  <= FHEIGHT_W'(240);
			cfg_q.filter_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_data[FWIDTH_W-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_data;
				end
				CFG_FILTER_ENABLE: begin
					cfg_q.filter_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Every accepted transaction goes through the front part; dropped items
	// simply produce no command.
	assign accept = push && !full;
	assign in_px  = {in_alpha, in_blue, in_green, in_red};

	wbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.kind     (kind),
		.px       (in_px),
		.cmd_push (cmd_push),
		.cmd      (cmd_front)
	);

	wbs_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.cmd_in  (cmd_front),
		.full    (full),
		.pop     (cmd_pop),
		.valid   (cmd_valid),
		.cmd_out (cmd_back)
	);

	wbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_in    (cmd_back),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign out_red    = res.px[0];
	assign out_green  = res.px[1];
	assign out_blue   = res.px[2];
	assign out_alpha  = res.px[3];
	assign out_col    = res.col;
	assign out_row    = res.row;
	assign frame_last = res.last;

endmodule

/* rtl/wbs_ram.sv */
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
module wbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

/* rtl/wbs_front.sv */
// Front part of the blur stream: accepts items, tracks the frame position and
// the drain count, and turns each item into a command or drops it.
// Depends on wbs_pkg.
module wbs_front import wbs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         accept,
	input  logic         kind,
	input  pixel_t       px,
	output logic         cmd_push,
	output cmd_t         cmd
);

	logic [COL_W-1:0]     input_col_q;
	logic [ROW_W-1:0]     input_row_q;
	logic [PEND_W-1:0]    pending_q;
	logic [FWIDTH_W-1:0]  drain_w_q;
	logic [FHEIGHT_W-1:0] drain_h_q;

	logic [FWIDTH_W-1:0]  eff_w;
	logic [FHEIGHT_W-1:0] eff_h;
	logic [COL_W-1:0]     wm1;
	logic [ROW_W-1:0]     hm1;
	logic [COL_W-1:0]     c;
	logic [ROW_W-1:0]     r;
	logic                 ready;
	logic [FWIDTH_W-1:0]  k;
	logic [COL_W-1:0]     dwm1;
	logic                 is_pixel;
	logic                 is_drain;

	always_comb begin
		eff_w = cfg.frame_width;
		if (cfg.frame_width < FWIDTH_W'(MIN_SIZE)) begin
			eff_w = FWIDTH_W'(MIN_SIZE);
		end else if (cfg.frame_width > FWIDTH_W'(MAX_WIDTH)) begin
			eff_w = FWIDTH_W'(MAX_WIDTH);
		end
		eff_h = cfg.frame_height;
		if (cfg.frame_height < FHEIGHT_W'(MIN_SIZE)) begin
			eff_h = FHEIGHT_W'(MIN_SIZE);
		end else if (cfg.frame_height > FHEIGHT_W'(MAX_HEIGHT)) begin
			eff_h = FHEIGHT_W'(MAX_HEIGHT);
		end
	end

	assign wm1 = COL_W'(eff_w - FWIDTH_W'(1));
	assign hm1 = ROW_W'(eff_h - FHEIGHT_W'(1));
	// A position past the current size counts as the last column or row.
	assign c = (input_col_q < wm1) ? input_col_q : wm1;
	assign r = (input_row_q < hm1) ? input_row_q : hm1;
	assign ready = (r >= ROW_W'(2)) || ((r == ROW_W'(1)) && (c >= COL_W'(1)));

	assign k    = drain_w_q + FWIDTH_W'(1) - pending_q;
	assign dwm1 = COL_W'(drain_w_q - FWIDTH_W'(1));

	// Pixels that arrive while a drain is open are dropped, and drain ticks
	// with nothing pending are ignored.
	assign is_pixel = accept && !kind && (pending_q == '0);
	assign is_drain = accept && kind && (pending_q != '0);
	assign cmd_push = is_pixel || is_drain;

	always_comb begin
		cmd = '0;
		cmd.px = px;
		if (kind) begin
			cmd.is_drain  = 1'b1;
			cmd.emit      = 1'b1;
			cmd.use_edge  = (k == '0);
			cmd.edge_addr = dwm1;
			cmd.col       = COL_W'(k - FWIDTH_W'(1));
			cmd.last      = (pending_q == PEND_W'(1));
			if (k == '0) begin
				cmd.ocol = dwm1;
				cmd.orow = ROW_W'(drain_h_q - FHEIGHT_W'(2));
			end else begin
				cmd.ocol = COL_W'(k - FWIDTH_W'(1));
				cmd.orow = ROW_W'(drain_h_q - FHEIGHT_W'(1));
			end
		end else begin
			cmd.emit      = ready;
			cmd.blur      = cfg.filter_enable && (c >= COL_W'(2)) && (r >= ROW_W'(2));
			cmd.use_edge  = (c == '0);
			cmd.col       = c;
			cmd.edge_addr = wm1;
			if (c == '0) begin
				cmd.ocol = wm1;
				cmd.orow = r - ROW_W'(2);
			end else begin
				cmd.ocol = c - COL_W'(1);
				cmd.orow = r - ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_col_q <= '0;
			input_row_q <= '0;
			pending_q   <= '0;
			drain_w_q   <= '0;
			drain_h_q   <= '0;
		end else if (is_drain) begin
			pending_q <= pending_q - PEND_W'(1);
		end else if (is_pixel) begin
			if (c == wm1) begin
				input_col_q <= '0;
				if (r == hm1) begin
					input_row_q <= '0;
					pending_q   <= PEND_W'(eff_w + FWIDTH_W'(1));
					drain_w_q   <= eff_w;
					drain_h_q   <= eff_h;
				end else begin
					input_row_q <= r + ROW_W'(1);
				end
			end else begin
				input_col_q <= c + COL_W'(1);
				input_row_q <= r;
			end
		end
	end

endmodule

/* rtl/wbs_cmd_queue.sv */
// Short command queue between the front and back parts of the blur stream.
// Depends on wbs_pkg.
module wbs_cmd_queue import wbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t cmd_out
);

	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t               slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(CMDQ_DEPTH));
	assign valid   = (count_q != '0);
	assign cmd_out = slot_q[rd_ptr_q];
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + CMDQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + CMDQ_AW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/wbs_back.sv */
// Back part of the blur stream: the two row stores, the 3x3 window, the
// weighted sum and divide by 18, and the result queue.
// Depends on wbs_pkg and wbs_ram.
module wbs_back import wbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd_in,
	output logic cmd_pop,
	input  logic pop,
	output logic empty,
	output res_t res
);

	typedef logic [2:0][SUM_W-1:0] sums_t;

	// Stage 1: store reads in flight.
	logic   valid_s1;
	cmd_t   cmd_s1;
	logic   fwd_a_s1;
	logic   fwd_b_s1;
	pixel_t fwd_data_s1;
	// Stage 2: weighted sums and the unfiltered pixel.
	logic              valid_s2;
	logic              blur_s2;
	sums_t             sum_s2;
	pixel_t            centre_s2;
	logic [COL_W-1:0]  col_s2;
	logic [ROW_W-1:0]  row_s2;
	logic              last_s2;

	pixel_t win_q [3][3];
	pixel_t win_next [3][3];

	pixel_t up_a_rdata;
	pixel_t up_b_rdata;
	pixel_t mid_rdata;
	pixel_t up_a;
	pixel_t up_b;
	pixel_t centre;
	logic   up_we;
	sums_t  sums;

	res_t                outq_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]  out_wr_q;
	logic [OUTQ_AW-1:0]  out_rd_q;
	logic [OUTQ_CW-1:0]  out_cnt_q;
	logic [OUTQ_CW:0]    committed;
	logic                out_pop;
	res_t                res_new;
	logic [RECIP_W+SUM_W-1:0] prod [3];

	// The upper store is kept twice so that the current column and the last
	// column can be read in the same cycle.
	assign up_we = valid_s1 && !cmd_s1.is_drain;

	wbs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper_a (
		.clk   (clk),
		.we    (up_we),
		.waddr (cmd_s1.col),
		.wdata (mid_rdata),
		.raddr (cmd_in.col),
		.rdata (up_a_rdata)
	);

	wbs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_upper_b (
		.clk   (clk),
		.we    (up_we),
		.waddr (cmd_s1.col),
		.wdata (mid_rdata),
		.raddr (cmd_in.edge_addr),
		.rdata (up_b_rdata)
	);

	wbs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (cmd_pop && !cmd_in.is_drain),
		.waddr (cmd_in.col),
		.wdata (cmd_in.px),
		.raddr (cmd_in.col),
		.rdata (mid_rdata)
	);

	// Take a command only if its result is sure to find a queue slot.
	assign committed = (OUTQ_CW+1)'(out_cnt_q) + (OUTQ_CW+1)'(valid_s1)
		+ (OUTQ_CW+1)'(valid_s2);
	assign cmd_pop = cmd_valid && (committed < (OUTQ_CW+1)'(OUTQ_DEPTH));

	// The upper store is written in the cycle after its read; forward that write.
	assign up_a = fwd_a_s1 ? fwd_data_s1 : up_a_rdata;
	assign up_b = fwd_b_s1 ? fwd_data_s1 : up_b_rdata;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i][0] = win_q[i][1];
			win_next[i][1] = win_q[i][2];
		end
		win_next[0][2] = up_a;
		win_next[1][2] = mid_rdata;
		win_next[2][2] = cmd_s1.px;
	end

	always_comb begin
		if (cmd_s1.use_edge) begin
			centre = up_b;
		end else if (cmd_s1.is_drain) begin
			centre = mid_rdata;
		end else begin
			centre = win_q[1][2];
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sums[ch] = (SUM_W'(win_next[1][1][ch]) << 3) + (SUM_W'(win_next[1][1][ch]) << 1);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!(i == 1 && j == 1)) begin
						sums[ch] = sums[ch] + SUM_W'(win_next[i][j][ch]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			valid_s1 <= cmd_pop;
			valid_s2 <= valid_s1 && cmd_s1.emit;
			if (up_we) begin
				win_q <= win_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1      <= cmd_in;
		fwd_a_s1    <= up_we && (cmd_s1.col == cmd_in.col);
		fwd_b_s1    <= up_we && (cmd_s1.col == cmd_in.edge_addr);
		fwd_data_s1 <= mid_rdata;
		blur_s2     <= cmd_s1.blur;
		sum_s2      <= sums;
		centre_s2   <= centre;
		col_s2      <= cmd_s1.ocol;
		row_s2      <= cmd_s1.orow;
		last_s2     <= cmd_s1.last;
	end

	always_comb begin
		res_new.col  = col_s2;
		res_new.row  = row_s2;
		res_new.last = last_s2;
		res_new.px   = centre_s2;
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = (RECIP_W+SUM_W)'(sum_s2[ch]) * (RECIP_W+SUM_W)'(RECIP_18);
		end
		if (blur_s2) begin
			res_new.px[3] = OPAQUE;
			for (int ch = 0; ch < 3; ch++) begin
				res_new.px[ch] = prod[ch][RECIP_SHIFT +: 8];
			end
		end
	end

	assign empty   = (out_cnt_q == '0);
	assign res     = outq_q[out_rd_q];
	assign out_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			outq_q[out_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s2) begin
				out_wr_q <= (out_wr_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : out_wr_q + OUTQ_AW'(1);
			end
			if (out_pop) begin
				out_rd_q <= (out_rd_q == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : out_rd_q + OUTQ_AW'(1);
			end
			if (valid_s2 && !out_pop) begin
				out_cnt_q <= out_cnt_q + OUTQ_CW'(1);
			end else if (!valid_s2 && out_pop) begin
				out_cnt_q <= out_cnt_q - OUTQ_CW'(1);
			end
		end
	end

endmodule
